// ===== design/isort_pkg.sv =====
// Shared request, result and control types of the insertion sort engine.
package isort_pkg;

  localparam int unsigned DataW = 32;

  // One input request: a run element and its end marker.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } isort_req_t;

  // One result: the next element in ascending order.
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    final_res;
    logic                    overflow;
  } isort_res_t;

  // Chain control broadcast to every cell.
  typedef struct packed {
    logic insert;  // compare against key, shift greater values right
    logic shift;   // drain: every cell takes its right neighbor
  } isort_ctrl_t;

endpackage

// ===== design/isort_cell.sv =====
// One compare-and-shift cell of the sorting chain.
module isort_cell import isort_pkg::*; (
  input  logic                    clk_i,
  input  isort_ctrl_t             ctrl_i,
  input  logic                    occ_i,
  input  logic signed [DataW-1:0] key_i,
  input  logic                    left_gt_i,
  input  logic signed [DataW-1:0] left_val_i,
  input  logic signed [DataW-1:0] right_val_i,
  output logic                    gt_o,
  output logic signed [DataW-1:0] val_o
);

  logic signed [DataW-1:0] val_q, val_d;

  // an empty cell counts as greater than any key
  assign gt_o  = !occ_i || (val_q > key_i);
  assign val_o = val_q;

  // insert: a greater value moves right; the first greater cell takes the key
  always_comb begin
    val_d = val_q;
    if (ctrl_i.shift) begin
      val_d = right_val_i;
    end else if (ctrl_i.insert && gt_o) begin
      val_d = left_gt_i ? left_val_i : key_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== design/insertion_sort_engine.sv =====
// Insertion sort engine: a chain of compare-and-shift cells with load and drain control.
//
// While busy is low, one value is accepted per clock (start high) and inserted in
// the same cycle: every cell compares it with its stored value and the greater ones
// move one cell to the right. Equal values keep their arrival order. The request
// marked last raises busy, and the values held (up to MAX_ITEMS) then come out on
// res_o with res_valid_o high, smallest first, as the chain shifts toward cell 0.
// The final result carries final_res. start is ignored while busy, and results
// cannot be held off: the receiver takes each one in the cycle it appears. Values
// beyond MAX_ITEMS are dropped and every result of that run carries overflow.
module insertion_sort_engine import isort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  isort_req_t req_i,
  output logic       busy,
  output logic       res_valid_o,
  output isort_res_t res_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            drop_q, drop_d;
  logic            ovf_q, ovf_d;
  logic            drain_q, drain_d;

  logic            accept;
  logic            full;
  isort_ctrl_t     ctrl;

  logic signed [DataW-1:0] cval [MAX_ITEMS];
  logic                    cgt  [MAX_ITEMS];

  assign accept      = start && !drain_q;
  assign full        = (fill_q == CntW'(MAX_ITEMS));
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = drain_q;

  // cell chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                    left_gt;
    logic signed [DataW-1:0] left_val;
    logic signed [DataW-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_mid
      assign left_gt  = cgt[i-1];
      assign left_val = cval[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_nxt
      assign right_val = cval[i+1];
    end

    isort_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (fill_q > CntW'(i)),
      .key_i       (req_i.value),
      .left_gt_i   (left_gt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .gt_o        (cgt[i]),
      .val_o       (cval[i])
    );
  end

  // load and drain control
  always_comb begin
    fill_d   = fill_q;
    remain_d = remain_q;
    drop_d   = drop_q;
    ovf_d    = ovf_q;
    drain_d  = drain_q;
    if (drain_q) begin
      remain_d = remain_q - 1'b1;
      if (remain_q == CntW'(1)) begin
        drain_d = 1'b0;
      end
    end else if (accept) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        fill_d = fill_q + 1'b1;
      end
      if (req_i.last) begin
        remain_d = full ? fill_q : fill_q + 1'b1;
        ovf_d    = drop_q || full;
        drain_d  = 1'b1;
        fill_d   = '0;
        drop_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      remain_q <= '0;
      drop_q   <= 1'b0;
      ovf_q    <= 1'b0;
      drain_q  <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      remain_q <= remain_d;
      drop_q   <= drop_d;
      ovf_q    <= ovf_d;
      drain_q  <= drain_d;
    end
  end

  // result ports
  assign busy               = drain_q;
  assign res_valid_o        = drain_q;
  assign res_o.sorted_value = cval[0];
  assign res_o.final_res    = (remain_q == CntW'(1));
  assign res_o.overflow     = ovf_q;

  // checks
  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.final_res |=> !busy)
    else $error("busy stays high after final result");

  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> remain_q != '0)
    else $error("draining with nothing left");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.last |=> busy && fill_q == '0)
    else $error("last request did not start drain");

endmodule
